[rtl/core/lab_pkg.sv]
// ----------------------------------------------------------------------------
// lab_pkg: shared types and constants of the look-at basis block
// Widths of the vector datapath, pipeline depths and the basis vectors.
// ----------------------------------------------------------------------------
package lab_pkg;

  localparam int COORD_W = 32;          // Q16.16 input coordinate
  localparam int VEC_W   = 34;          // signed vector entering a normaliser
  localparam int NM_W    = 31;          // normalised magnitude, top bit at NM_W-1
  localparam int SQ_W    = 2 * NM_W;    // one squared magnitude
  localparam int SUM_W   = 64;          // sum of three squares
  localparam int ROOT_W  = SUM_W / 2;   // integer square root
  localparam int REM_W   = ROOT_W + 2;  // square-root remainder
  localparam int FRAC_W  = 14;          // Q1.14 fraction bits
  localparam int Q_W     = FRAC_W + 1;  // quotient magnitude, up to 1.0
  localparam int NUM_W   = NM_W + FRAC_W + 1;
  localparam int OUT_W   = 16;          // Q1.14 component
  localparam int EPS_W   = 15;

  localparam int SQRT_PER    = 2;                   // root bits per stage
  localparam int SQRT_STAGES = ROOT_W / SQRT_PER;
  localparam int DIV_PER     = 3;                   // quotient bits per stage
  localparam int DIV_STAGES  = Q_W / DIV_PER;

  localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(1);
  localparam logic signed [OUT_W-1:0] ONE_Q14 = OUT_W'(16384);

  typedef struct packed {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
  } q14v_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [VEC_W-1:0] z;
  } wvec_t;

  // Candidate temporary up vectors.
  localparam q14v_t UP_NEG_Z = '{x: '0, y: '0, z: -ONE_Q14};
  localparam q14v_t UP_POS_Z = '{x: '0, y: '0, z: ONE_Q14};
  localparam q14v_t UP_POS_Y = '{x: '0, y: ONE_Q14, z: '0};

  typedef struct packed {
    logic  deg;
    q14v_t fwd;
  } side2_t;

  typedef struct packed {
    logic  deg;
    q14v_t fwd;
    q14v_t left;
  } side3_t;

  typedef struct packed {
    logic  deg;
    q14v_t fwd;
    q14v_t up;
    q14v_t left;
  } basis_t;

endpackage

[rtl/core/lab_norm.sv]
// ----------------------------------------------------------------------------
// lab_norm: pipelined vector normaliser
// Scales a signed vector to unit length with Q1.14 components, through a
// shift normalisation, a bit-pair square root and a restoring divider.
// ----------------------------------------------------------------------------
module lab_norm #(
  parameter int SIDE_W = lab_pkg::EPS_W
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  lab_pkg::wvec_t        vin,
  input  logic [SIDE_W-1:0]     side_in,
  output logic                  out_valid,
  output lab_pkg::q14v_t        vout,
  output logic                  out_zero,
  output logic [SIDE_W-1:0]     side_out
);

  localparam int VW = lab_pkg::VEC_W;
  localparam int NW = lab_pkg::NM_W;
  localparam int SS = lab_pkg::SQRT_STAGES;
  localparam int DS = lab_pkg::DIV_STAGES;
  localparam int RW = lab_pkg::ROOT_W;
  localparam int QW = lab_pkg::Q_W;

  logic signed [VW-1:0] vi [3];
  assign vi[0] = vin.x;
  assign vi[1] = vin.y;
  assign vi[2] = vin.z;

  // Stage 1: sign and magnitude.
  logic              v1;
  logic              neg1 [3];
  logic [VW-1:0]     mag1 [3];
  logic [SIDE_W-1:0] side1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg1[i] <= vi[i][VW-1];
        mag1[i] <= vi[i][VW-1] ? VW'(-vi[i]) : VW'(vi[i]);
      end
      side1 <= side_in;
    end
  end

  // Stage 2: the OR of the magnitudes leads where the largest one does, so it
  // steers the shifts. Right shift by up to three, then left by 16 and 8.
  logic [VW-1:0] or_a;
  logic [VW-1:0] or_b;
  logic [1:0]    rs;
  logic [NW-1:0] orc2;
  logic [NW-1:0] mc2 [3];

  always_comb begin
    or_a = mag1[0] | mag1[1] | mag1[2];
    if (or_a[VW-1]) begin
      rs = 2'd3;
    end else if (or_a[VW-2]) begin
      rs = 2'd2;
    end else if (or_a[VW-3]) begin
      rs = 2'd1;
    end else begin
      rs = 2'd0;
    end
    or_b = or_a >> rs;
    orc2 = or_b[NW-1:0];
    for (int i = 0; i < 3; i++) begin
      mc2[i] = NW'(mag1[i] >> rs);
    end
    if (orc2[NW-1 -: 16] == '0) begin
      orc2 = orc2 << 16;
      for (int i = 0; i < 3; i++) mc2[i] = mc2[i] << 16;
    end
    if (orc2[NW-1 -: 8] == '0) begin
      orc2 = orc2 << 8;
      for (int i = 0; i < 3; i++) mc2[i] = mc2[i] << 8;
    end
  end

  logic              v2;
  logic              neg2 [3];
  logic [NW-1:0]     m2 [3];
  logic [NW-1:0]     or2;
  logic              zero2;
  logic [SIDE_W-1:0] side2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg2  <= neg1;
      m2    <= mc2;
      or2   <= orc2;
      zero2 <= (or_a == '0);
      side2 <= side1;
    end
  end

  // Stage 3: left shifts by 4, 2 and 1.
  logic [NW-1:0] orc3;
  logic [NW-1:0] mc3 [3];

  always_comb begin
    orc3 = or2;
    mc3  = m2;
    if (orc3[NW-1 -: 4] == '0) begin
      orc3 = orc3 << 4;
      for (int i = 0; i < 3; i++) mc3[i] = mc3[i] << 4;
    end
    if (orc3[NW-1 -: 2] == '0) begin
      orc3 = orc3 << 2;
      for (int i = 0; i < 3; i++) mc3[i] = mc3[i] << 2;
    end
    if (!orc3[NW-1]) begin
      for (int i = 0; i < 3; i++) mc3[i] = mc3[i] << 1;
    end
  end

  logic              v3;
  logic              neg3 [3];
  logic [NW-1:0]     m3 [3];
  logic              zero3;
  logic [SIDE_W-1:0] side3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg3  <= neg2;
      m3    <= mc3;
      zero3 <= zero2;
      side3 <= side2;
    end
  end

  // Stage 4: squares.
  logic                     v4;
  logic                     neg4 [3];
  logic [NW-1:0]            m4 [3];
  logic [lab_pkg::SQ_W-1:0] sq4 [3];
  logic                     zero4;
  logic [SIDE_W-1:0]        side4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq4[i] <= lab_pkg::SQ_W'(m3[i]) * lab_pkg::SQ_W'(m3[i]);
      end
      neg4  <= neg3;
      m4    <= m3;
      zero4 <= zero3;
      side4 <= side3;
    end
  end

  // Stage 5 and the square-root pipeline.
  logic [lab_pkg::SUM_W-1:0] sq_s    [SS];
  logic [lab_pkg::REM_W-1:0] sq_rem  [SS];
  logic [RW-1:0]             sq_root [SS+1];
  logic [NW-1:0]             sq_m    [SS+1][3];
  logic                      sq_neg  [SS+1][3];
  logic                      sq_zero [SS+1];
  logic [SIDE_W-1:0]         sq_side [SS+1];
  logic                      sq_v    [SS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else if (en) begin
      sq_v[0] <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_s[0]    <= lab_pkg::SUM_W'(sq4[0]) + lab_pkg::SUM_W'(sq4[1])
                    + lab_pkg::SUM_W'(sq4[2]);
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      sq_m[0]    <= m4;
      sq_neg[0]  <= neg4;
      sq_zero[0] <= zero4;
      sq_side[0] <= side4;
    end
  end

  for (genvar k = 0; k < SS; k++) begin : g_sqrt
    logic [lab_pkg::SUM_W-1:0] s_w;
    logic [lab_pkg::REM_W-1:0] rem_w;
    logic [RW-1:0]             root_w;
    logic [lab_pkg::REM_W+1:0] t_w;
    logic [lab_pkg::REM_W+1:0] trial_w;

    always_comb begin
      s_w    = sq_s[k];
      rem_w  = sq_rem[k];
      root_w = sq_root[k];
      t_w    = '0;
      trial_w = '0;
      for (int j = 0; j < lab_pkg::SQRT_PER; j++) begin
        t_w     = {rem_w, s_w[lab_pkg::SUM_W-1 -: 2]};
        trial_w = (lab_pkg::REM_W+2)'({root_w, 2'b01});
        if (t_w >= trial_w) begin
          rem_w  = lab_pkg::REM_W'(t_w - trial_w);
          root_w = {root_w[RW-2:0], 1'b1};
        end else begin
          rem_w  = lab_pkg::REM_W'(t_w);
          root_w = {root_w[RW-2:0], 1'b0};
        end
        s_w = s_w << 2;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k+1] <= 1'b0;
      end else if (en) begin
        sq_v[k+1] <= sq_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_root[k+1] <= root_w;
        sq_m[k+1]    <= sq_m[k];
        sq_neg[k+1]  <= sq_neg[k];
        sq_zero[k+1] <= sq_zero[k];
        sq_side[k+1] <= sq_side[k];
      end
    end

    if (k < SS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          sq_s[k+1]   <= s_w;
          sq_rem[k+1] <= rem_w;
        end
      end
    end
  end

  // Divider set-up: numerator m * 2^14 + L/2 for each component.
  logic [RW-1:0]             dv_l    [DS];
  logic [RW-1:0]             dv_rem  [DS];
  logic [QW-1:0]             dv_low  [DS][3];
  logic [RW-1:0]             dv_r    [DS][3];
  logic [QW-1:0]             dv_q    [DS+1][3];
  logic                      dv_neg  [DS+1][3];
  logic                      dv_zero [DS+1];
  logic [SIDE_W-1:0]         dv_side [DS+1];
  logic                      dv_v    [DS+1];
  logic [lab_pkg::NUM_W-1:0] num_c   [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num_c[i] = (lab_pkg::NUM_W'(sq_m[SS][i]) << lab_pkg::FRAC_W)
                 + lab_pkg::NUM_W'(sq_root[SS] >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= sq_v[SS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_l[0] <= sq_root[SS];
      for (int i = 0; i < 3; i++) begin
        dv_r[0][i]   <= RW'(num_c[i][lab_pkg::NUM_W-1:QW]);
        dv_low[0][i] <= num_c[i][QW-1:0];
        dv_q[0][i]   <= '0;
      end
      dv_neg[0]  <= sq_neg[SS];
      dv_zero[0] <= sq_zero[SS];
      dv_side[0] <= sq_side[SS];
    end
  end

  assign dv_rem[0] = dv_l[0];

  for (genvar k = 0; k < DS; k++) begin : g_div
    logic [RW-1:0] r_w   [3];
    logic [QW-1:0] low_w [3];
    logic [QW-1:0] q_w   [3];
    logic [RW:0]   t_w   [3];
    logic          ge    [3];

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        r_w[i]   = dv_r[k][i];
        low_w[i] = dv_low[k][i];
        q_w[i]   = dv_q[k][i];
        t_w[i]   = '0;
        ge[i]    = 1'b0;
        for (int j = 0; j < lab_pkg::DIV_PER; j++) begin
          t_w[i]   = {r_w[i], low_w[i][QW-1]};
          ge[i]    = (t_w[i] >= {1'b0, dv_rem[k]});
          r_w[i]   = ge[i] ? RW'(t_w[i] - {1'b0, dv_rem[k]}) : RW'(t_w[i]);
          q_w[i]   = {q_w[i][QW-2:0], ge[i]};
          low_w[i] = low_w[i] << 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[k+1] <= 1'b0;
      end else if (en) begin
        dv_v[k+1] <= dv_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_q[k+1]    <= q_w;
        dv_neg[k+1]  <= dv_neg[k];
        dv_zero[k+1] <= dv_zero[k];
        dv_side[k+1] <= dv_side[k];
      end
    end

    if (k < DS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          dv_l[k+1] <= dv_l[k];
          dv_r[k+1] <= r_w;
          dv_low[k+1] <= low_w;
        end
      end
      assign dv_rem[k+1] = dv_l[k+1];
    end
  end

  // Output stage: sign restored, forced to zero for a zero-length vector.
  logic signed [lab_pkg::OUT_W-1:0] qs [3];
  logic signed [lab_pkg::OUT_W-1:0] vo [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qs[i] = lab_pkg::OUT_W'(dv_q[DS][i]);
      vo[i] = dv_zero[DS] ? '0 : (dv_neg[DS][i] ? -qs[i] : qs[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_v[DS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vout.x   <= vo[0];
      vout.y   <= vo[1];
      vout.z   <= vo[2];
      out_zero <= dv_zero[DS];
      side_out <= dv_side[DS];
    end
  end

endmodule

[rtl/core/lab_cross.sv]
// ----------------------------------------------------------------------------
// lab_cross: two-stage cross product
// Six Q1.14 products in the first stage, the differences in the second.
// ----------------------------------------------------------------------------
module lab_cross #(
  parameter int SIDE_W = $bits(lab_pkg::side2_t)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  lab_pkg::q14v_t    a,
  input  lab_pkg::q14v_t    b,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output lab_pkg::wvec_t    c,
  output logic [SIDE_W-1:0] side_out
);

  localparam int PW = 2 * lab_pkg::OUT_W;

  logic                 v1;
  logic signed [PW-1:0] p [6];
  logic [SIDE_W-1:0]    side1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p[0]  <= a.y * b.z;
      p[1]  <= a.z * b.y;
      p[2]  <= a.z * b.x;
      p[3]  <= a.x * b.z;
      p[4]  <= a.x * b.y;
      p[5]  <= a.y * b.x;
      side1 <= side_in;
      c.x   <= lab_pkg::VEC_W'(p[0]) - lab_pkg::VEC_W'(p[1]);
      c.y   <= lab_pkg::VEC_W'(p[2]) - lab_pkg::VEC_W'(p[3]);
      c.z   <= lab_pkg::VEC_W'(p[4]) - lab_pkg::VEC_W'(p[5]);
      side_out <= side1;
    end
  end

endmodule

[rtl/core/lab_obuf.sv]
// ----------------------------------------------------------------------------
// lab_obuf: two-entry output buffer
// Holds finished results so that the pipeline keeps moving while the
// consumer stalls; its ready comes from the registered fill count.
// ----------------------------------------------------------------------------
module lab_obuf #(
  parameter int W = $bits(lab_pkg::basis_t)
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         ready,
  output logic         valid,
  output logic [W-1:0] dout,
  input  logic         take
);

  localparam logic [1:0] DEPTH = 2'd2;

  logic [W-1:0] mem [2];
  logic         wp;
  logic         rp;
  logic [1:0]   cnt;
  logic [1:0]   cnt_next;
  logic         pop;

  assign ready = (cnt != DEPTH);
  assign valid = (cnt != 2'd0);
  assign dout  = mem[rp];
  assign pop   = valid && take;

  always_comb begin
    case ({push, pop})
      2'b10:   cnt_next = cnt + 2'd1;
      2'b01:   cnt_next = cnt - 2'd1;
      default: cnt_next = cnt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= din;
  end

endmodule

[rtl/core/look_at_basis.sv]
// ----------------------------------------------------------------------------
// look_at_basis: orthonormal look-at camera basis
// From a camera position and a target point in Q16.16 this block produces
// the left, up and forward unit vectors of the camera in Q1.14.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake            Word
//  s_       in         s_tvalid/s_tready    position and target, six Q16.16
//  m_       out        m_tvalid/m_tready    nine Q1.14 components, flag tuser
//  cfg_     in         cfg_valid/cfg_ready  axis_epsilon, 15 bits
//
// One word is accepted every cycle while the output buffer has room. From
// acceptance to m_ a word passes three normalisers of 28 stages each,
// dominated by their 16-stage square-root pipelines, plus the difference and
// up-selection stages and the two cross products. Reset clears all valid bits
// and sets axis_epsilon to 1. A stall on m_ freezes the whole pipeline only
// once the two-entry output buffer is full, so one finished word may wait
// while new words are still taken.
//
module look_at_basis (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // pos_x, pos_y, pos_z, tgt_x, tgt_y, tgt_z, 32 bits each from the lowest.
  input  logic [191:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // left_x, left_y, left_z, up_x, up_y, up_z, fwd_x, fwd_y, fwd_z, 16 bits
  // each from the lowest.
  output logic [143:0] m_tdata,
  // degenerate.
  output logic [0:0]   m_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [14:0]  cfg_data
);

  localparam int CW = lab_pkg::COORD_W;
  localparam int VW = lab_pkg::VEC_W;
  localparam int EW = lab_pkg::EPS_W;
  localparam int S2 = $bits(lab_pkg::side2_t);
  localparam int S3 = $bits(lab_pkg::side3_t);

  // The threshold register. The user must write it only while the pipeline is empty;
  // the block does not enforce this. Each word carries its own copy through the first normaliser.
  logic [EW-1:0] eps;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      eps <= lab_pkg::EPS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      eps <= cfg_data;
    end
  end

  // The whole pipeline advances together while the output buffer has room.
  logic en;
  assign s_tready = en;

  // Difference stage: target minus position, formed exactly.
  logic           d_v;
  lab_pkg::wvec_t d_vec;
  logic [EW-1:0]  d_eps;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
    end else if (en) begin
      d_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_vec.x <= VW'($signed(s_tdata[4*CW-1:3*CW])) - VW'($signed(s_tdata[CW-1:0]));
      d_vec.y <= VW'($signed(s_tdata[5*CW-1:4*CW])) - VW'($signed(s_tdata[2*CW-1:CW]));
      d_vec.z <= VW'($signed(s_tdata[6*CW-1:5*CW])) - VW'($signed(s_tdata[3*CW-1:2*CW]));
      d_eps   <= eps;
    end
  end

  // Forward vector.
  logic           n1_v;
  lab_pkg::q14v_t n1_f;
  logic           n1_zero;
  logic [EW-1:0]  n1_eps;

  lab_norm #(.SIDE_W(EW)) u_norm_fwd (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (d_v),
    .vin      (d_vec),
    .side_in  (d_eps),
    .out_valid(n1_v),
    .vout     (n1_f),
    .out_zero (n1_zero),
    .side_out (n1_eps)
  );

  // Temporary up: +Y, unless forward is nearly vertical, in which case a
  // Z axis is used: -Z when forward y is positive, +Z otherwise.
  logic [lab_pkg::OUT_W-1:0] abs_x;
  logic [lab_pkg::OUT_W-1:0] abs_z;
  logic                      vert;
  lab_pkg::q14v_t            upt_c;

  always_comb begin
    abs_x = n1_f.x[lab_pkg::OUT_W-1] ? lab_pkg::OUT_W'(-n1_f.x) : n1_f.x;
    abs_z = n1_f.z[lab_pkg::OUT_W-1] ? lab_pkg::OUT_W'(-n1_f.z) : n1_f.z;
    vert  = (abs_x < {1'b0, n1_eps}) && (abs_z < {1'b0, n1_eps});
    if (!vert) begin
      upt_c = lab_pkg::UP_POS_Y;
    end else if (n1_f.y > 0) begin
      upt_c = lab_pkg::UP_NEG_Z;
    end else begin
      upt_c = lab_pkg::UP_POS_Z;
    end
  end

  logic             u_v;
  lab_pkg::q14v_t   u_a;
  lab_pkg::side2_t  u_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      u_v <= 1'b0;
    end else if (en) begin
      u_v <= n1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_a        <= upt_c;
      u_side.fwd <= n1_f;
      u_side.deg <= n1_zero;
    end
  end

  // Left = normalise(up_tmp x forward).
  logic            c1_v;
  lab_pkg::wvec_t  c1_c;
  lab_pkg::side2_t c1_side;

  lab_cross #(.SIDE_W(S2)) u_cross_left (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (u_v),
    .a        (u_a),
    .b        (u_side.fwd),
    .side_in  (u_side),
    .out_valid(c1_v),
    .c        (c1_c),
    .side_out (c1_side)
  );

  logic            n2_v;
  lab_pkg::q14v_t  n2_l;
  logic            n2_zero;
  lab_pkg::side2_t n2_side;

  lab_norm #(.SIDE_W(S2)) u_norm_left (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (c1_v),
    .vin      (c1_c),
    .side_in  (c1_side),
    .out_valid(n2_v),
    .vout     (n2_l),
    .out_zero (n2_zero),
    .side_out (n2_side)
  );

  // Up = normalise(forward x left).
  lab_pkg::side3_t c2_in;

  always_comb begin
    c2_in.deg  = n2_side.deg | n2_zero;
    c2_in.fwd  = n2_side.fwd;
    c2_in.left = n2_l;
  end

  logic            c2_v;
  lab_pkg::wvec_t  c2_c;
  lab_pkg::side3_t c2_side;

  lab_cross #(.SIDE_W(S3)) u_cross_up (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (n2_v),
    .a        (n2_side.fwd),
    .b        (n2_l),
    .side_in  (c2_in),
    .out_valid(c2_v),
    .c        (c2_c),
    .side_out (c2_side)
  );

  logic            n3_v;
  lab_pkg::q14v_t  n3_u;
  logic            n3_zero;
  lab_pkg::side3_t n3_side;

  lab_norm #(.SIDE_W(S3)) u_norm_up (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (c2_v),
    .vin      (c2_c),
    .side_in  (c2_side),
    .out_valid(n3_v),
    .vout     (n3_u),
    .out_zero (n3_zero),
    .side_out (n3_side)
  );

  // Any zero length along the way blanks the whole basis.
  lab_pkg::basis_t res;
  lab_pkg::basis_t outw;

  always_comb begin
    res.deg = n3_side.deg | n3_zero;
    if (res.deg) begin
      res.fwd  = '0;
      res.up   = '0;
      res.left = '0;
    end else begin
      res.fwd  = n3_side.fwd;
      res.up   = n3_u;
      res.left = n3_side.left;
    end
  end

  lab_obuf #(.W($bits(lab_pkg::basis_t))) u_obuf (
    .clk  (clk),
    .rst  (rst),
    .push (n3_v && en),
    .din  (res),
    .ready(en),
    .valid(m_tvalid),
    .dout (outw),
    .take (m_tready)
  );

  assign m_tdata = {outw.fwd.z, outw.fwd.y, outw.fwd.x,
                    outw.up.z,  outw.up.y,  outw.up.x,
                    outw.left.z, outw.left.y, outw.left.x};
  assign m_tuser = outw.deg;

`ifndef SYNTHESIS
  // A degenerate word carries an all-zero basis.
  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '0)
    else $error("degenerate word with non-zero components");

  // A valid basis has a forward vector of unit length, never all zero.
  a_fwd_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[143:96] != '0)
    else $error("non-degenerate word with zero forward vector");

  // Forward x stays within plus and minus one.
  a_fwd_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[111:96]) <= lab_pkg::ONE_Q14) &&
                 ($signed(m_tdata[111:96]) >= -lab_pkg::ONE_Q14))
    else $error("forward x out of range");

  // Input back-pressure only arises with a full buffer, hence a word waiting.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no word waiting on the output");
`endif

endmodule

[bench/basis_checker.sv]
// ----------------------------------------------------------------------------
// basis_checker: predicts and checks the camera basis words
// Watches the input, output and epsilon channels of look_at_basis, works out
// the expected basis for every accepted word and compares it on arrival.
// ----------------------------------------------------------------------------
module basis_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [191:0] s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [143:0] m_tdata,
  input  logic [0:0]   m_tuser,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [14:0]  cfg_data,
  output int           pending,
  output int           errors
);

  typedef struct {
    logic [143:0] comps;
    logic         deg;
  } basis_word_t;

  basis_word_t    basis_due[$];
  logic [lab_pkg::EPS_W-1:0] epsilon;

  function automatic longint unsigned int_root(input longint unsigned s);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b   = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s   = s - (res + b);
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Scales the vector so its largest magnitude sits in [2^30, 2^31), then
  // divides by the truncated length with rounding half up.
  function automatic bit unit_vec(input longint v [3], output longint o [3]);
    longint unsigned m [3];
    bit              neg [3];
    longint unsigned mx, sum, len, q;
    mx = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = v[i] < 0;
      m[i]   = neg[i] ? -v[i] : v[i];
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      for (int i = 0; i < 3; i++) o[i] = 0;
      return 0;
    end
    while (mx >= 64'h8000_0000) begin
      for (int i = 0; i < 3; i++) m[i] >>= 1;
      mx >>= 1;
    end
    while (mx < 64'h4000_0000) begin
      for (int i = 0; i < 3; i++) m[i] <<= 1;
      mx <<= 1;
    end
    for (int i = 0; i < 3; i++) sum += m[i] * m[i];
    len = int_root(sum);
    for (int i = 0; i < 3; i++) begin
      q    = (m[i] * 16384 + (len >> 1)) / len;
      o[i] = neg[i] ? -longint'(q) : longint'(q);
    end
    return 1;
  endfunction

  function automatic void cross_prod(input longint a [3], input longint b [3],
                                     output longint r [3]);
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic basis_word_t camera_basis(input logic [191:0] pts,
                                               input logic [lab_pkg::EPS_W-1:0] eps);
    longint      d [3], fwd [3], upt [3], c [3], lft [3], up [3];
    bit          ok;
    basis_word_t w;
    for (int i = 0; i < 3; i++)
      d[i] = longint'($signed(pts[96 + 32*i +: 32])) - longint'($signed(pts[32*i +: 32]));
    ok = unit_vec(d, fwd);
    if (ok) begin
      upt[0] = 0;
      upt[1] = 0;
      upt[2] = 0;
      if ((fwd[0] < 0 ? -fwd[0] : fwd[0]) < longint'(eps) &&
          (fwd[2] < 0 ? -fwd[2] : fwd[2]) < longint'(eps))
        upt[2] = fwd[1] > 0 ? -16384 : 16384;
      else
        upt[1] = 16384;
      cross_prod(upt, fwd, c);
      ok = unit_vec(c, lft);
    end
    if (ok) begin
      cross_prod(fwd, lft, c);
      ok = unit_vec(c, up);
    end
    for (int i = 0; i < 3; i++) begin
      w.comps[16*i +: 16]     = ok ? lft[i][15:0] : '0;
      w.comps[48 + 16*i +: 16] = ok ? up[i][15:0] : '0;
      w.comps[96 + 16*i +: 16] = ok ? fwd[i][15:0] : '0;
    end
    w.deg = !ok;
    return w;
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("basis_checker: %s got %0d expected %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    basis_word_t w;
    if (rst) begin
      epsilon = lab_pkg::EPS_RESET;
      errors  = 0;
      basis_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) epsilon = cfg_data;
      if (s_tvalid && s_tready) basis_due.push_back(camera_basis(s_tdata, epsilon));
      if (m_tvalid && m_tready) begin
        if (basis_due.size() == 0) begin
          report("unexpected word, count", 1, 0);
        end else begin
          w = basis_due.pop_front();
          for (int i = 0; i < 9; i++)
            if (m_tdata[16*i +: 16] !== w.comps[16*i +: 16])
              report($sformatf("component %0d", i), $signed(m_tdata[16*i +: 16]),
                     $signed(w.comps[16*i +: 16]));
          if (m_tuser[0] !== w.deg) report("degenerate", m_tuser[0], w.deg);
        end
      end
    end
    pending <= basis_due.size();
  end

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for look_at_basis
// Sends camera and target points through several epsilon settings, with
// random gaps on both sides; the checker beside the block judges each word.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int IDLE_LIMIT = 5000;   // far above latency plus longest stall
  localparam int DRAIN_WAIT = 120;    // a little over the pipeline latency

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [191:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [143:0] m_tdata;
  logic [0:0]   m_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [14:0]  cfg_data = '0;
  int           pending;
  int           errors;
  int           sent = 0;
  int           idle_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  look_at_basis dut (.*);

  basis_checker checker_i (.*);

  // Most often no gap, otherwise mostly short ones and now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Receiver: random stalls, plus one long hold-off once the stream is
  // under way, so that the output buffer and then the pipeline fill up.
  initial begin
    bit squeezed;
    int hold;
    squeezed = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!squeezed && sent >= 150) begin
        squeezed = 1;
        m_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      hold = gap_len();
      if (hold > 0) begin
        m_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
    end
  end

  // Watchdog on cycles in which no word moves on any channel.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  task automatic send_points(input logic signed [31:0] px, py, pz, tx, ty, tz);
    int g;
    s_tvalid <= 1'b1;
    s_tdata  <= {tz, ty, tx, pz, py, px};
    do @(posedge clk); while (!s_tready);
    sent++;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // The epsilon register is only written with the pipeline empty; every
  // word yields a result, so an empty scoreboard means the block is idle.
  task automatic set_epsilon(input logic [14:0] eps);
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= eps;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // One random query: fully random, a short offset, a near-vertical view,
  // or a coincident pair.
  task automatic random_query();
    logic signed [31:0] px, py, pz, dx, dy, dz;
    int kind;
    px = $urandom;
    py = $urandom;
    pz = $urandom;
    kind = $urandom_range(0, 9);
    if (kind < 3) begin
      dx = $urandom;
      dy = $urandom;
      dz = $urandom;
    end else if (kind < 6) begin
      dx = $signed($urandom_range(0, 2000)) - 1000;
      dy = $signed($urandom_range(0, 2000)) - 1000;
      dz = $signed($urandom_range(0, 2000)) - 1000;
    end else if (kind < 9) begin
      dx = $signed($urandom_range(0, 2000)) - 1000;
      dz = $signed($urandom_range(0, 2000)) - 1000;
      dy = $urandom_range(1 << 16, 1 << 30);
      if ($urandom_range(0, 1)) dy = -dy;
    end else begin
      dx = 0;
      dy = 0;
      dz = 0;
    end
    send_points(px, py, pz, px + dx, py + dy, pz + dz);
  endtask

  initial begin
    logic signed [31:0] lo, hi;
    lo = 32'sh8000_0000;
    hi = 32'sh7fff_ffff;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed cases at the reset epsilon of one.
    send_points(0, 0, 0, 0, 0, 0);                       // coincident points
    send_points(lo, hi, lo, lo, hi, lo);                 // coincident at extremes
    send_points(lo, lo, lo, hi, hi, hi);                 // largest difference
    send_points(hi, hi, hi, lo, lo, lo);                 // largest negative
    send_points(0, 0, 0, 32'sh10000, 0, 0);              // along +X
    send_points(0, 0, 0, 0, 32'sh10000, 0);              // straight up: -Z helper
    send_points(0, 0, 0, 0, -32'sh10000, 0);             // straight down: +Z helper
    send_points(0, 0, 0, 0, 0, 32'sh10000);              // along +Z
    send_points(5, 7, 9, 6, 7, 9);                       // one-bit offset
    send_points(0, 0, 0, 1, 32'sh4000_0000, 0);          // nearly vertical
    send_points(lo, 0, 0, hi, 0, 0);                     // across the full X range

    // Epsilon zero: a vertical view leaves the cross product at zero.
    set_epsilon(15'd0);
    send_points(0, 0, 0, 0, 32'sh30000, 0);
    send_points(0, hi, 0, 0, lo, 0);
    send_points(0, 0, 0, 1, 32'sh4000_0000, 0);
    send_points(3, 3, 3, 3, 3, 3);

    // Largest legal epsilon and the top of the register.
    set_epsilon(15'd16384);
    send_points(0, 0, 0, 32'sh10000, 0, 0);
    send_points(0, 0, 0, 32'sh10000, 32'sh10000, 32'sh10000);
    send_points(0, 0, 0, 0, -32'sh10000, 32'sh100);
    set_epsilon(15'h7fff);
    send_points(0, 0, 0, 0, 0, 32'sh10000);
    send_points(lo, lo, lo, hi, hi, hi);
    for (int i = 0; i < 40; i++) random_query();

    // Random phases with random epsilon, mostly around the size that
    // near-vertical views produce so both helper branches are taken.
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 5) set_epsilon(15'($urandom));
      else set_epsilon(15'($urandom_range(0, 400)));
      for (int i = 0; i < 210; i++) random_query();
    end
    s_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule
